FILE: rtl/assert_macros.svh
// Assertion helpers. Each macro samples on the rising clock edge and is
// switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spk_pkg.sv
`default_nettype none

package spk_pkg;

    localparam int WORD_W      = 64;
    localparam int ROUNDS_DEF  = 34;
    localparam int ROT_A       = 8;
    localparam int ROT_B       = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd4;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_PRIME,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_sched_ctl;

    typedef struct packed {
        logic load;
        logic step;
        logic dir;
    } t_round_ctl;

    function automatic t_word rotr(input t_word v, input int s);
        rotr = (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic t_word rotl(input t_word v, input int s);
        rotl = (v << s) | (v >> (WORD_W - s));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/spk_ram.sv
`default_nettype none

module spk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 34,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/spk_sched.sv
`default_nettype none

module spk_sched #(
    parameter int ROUNDS = spk_pkg::ROUNDS_DEF,
    localparam int IW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1
) (
    input  wire logic               i_clk,
    input  wire spk_pkg::t_sched_ctl i_ctl,
    input  wire logic [IW-1:0]      i_idx,
    input  wire spk_pkg::t_word     i_key0,
    input  wire spk_pkg::t_word     i_key1,
    input  wire spk_pkg::t_word     i_key2,
    input  wire spk_pkg::t_word     i_key3,
    output spk_pkg::t_word          o_rk
);

    spk_pkg::t_word r_k;
    spk_pkg::t_word r_l0;
    spk_pkg::t_word r_l1;
    spk_pkg::t_word r_l2;
    spk_pkg::t_word fresh;

    assign fresh = (spk_pkg::rotr(r_l0, spk_pkg::ROT_A) + r_k)
                   ^ spk_pkg::WORD_W'(i_idx);
    assign o_rk  = r_k;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_k  <= i_key3;
            r_l0 <= i_key2;
            r_l1 <= i_key1;
            r_l2 <= i_key0;
        end else if (i_ctl.step) begin
            r_k  <= spk_pkg::rotl(r_k, spk_pkg::ROT_B) ^ fresh;
            r_l0 <= r_l1;
            r_l1 <= r_l2;
            r_l2 <= fresh;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spk_round.sv
`default_nettype none

module spk_round (
    input  wire logic               i_clk,
    input  wire spk_pkg::t_round_ctl i_ctl,
    input  wire spk_pkg::t_word     i_x,
    input  wire spk_pkg::t_word     i_y,
    input  wire spk_pkg::t_word     i_rk,
    output spk_pkg::t_word          o_x,
    output spk_pkg::t_word          o_y
);

    spk_pkg::t_word r_x;
    spk_pkg::t_word r_y;
    spk_pkg::t_word enc_x;
    spk_pkg::t_word enc_y;
    spk_pkg::t_word dec_x;
    spk_pkg::t_word dec_y;

    always_comb begin
        enc_x = (spk_pkg::rotr(r_x, spk_pkg::ROT_A) + r_y) ^ i_rk;
        enc_y = spk_pkg::rotl(r_y, spk_pkg::ROT_B) ^ enc_x;
        dec_y = spk_pkg::rotr(r_x ^ r_y, spk_pkg::ROT_B);
        dec_x = spk_pkg::rotl((r_x ^ i_rk) - dec_y, spk_pkg::ROT_A);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x;
            r_y <= i_y;
        end else if (i_ctl.step) begin
            r_x <= i_ctl.dir ? dec_x : enc_x;
            r_y <= i_ctl.dir ? dec_y : enc_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

FILE: rtl/speck_block_cipher.sv
// Speck 128/256 block cipher, one block per beat in codebook fashion. The four key
// words and the direction must be written by the user through the configuration port
// only while the block is idle; the block itself does not enforce this. The first
// block after reset or after any key word write first expands the key into ROUNDS
// round keys held in a single-port-write, registered-read RAM, one key per cycle. Each
// block then takes one round per cycle through a shared round unit fed from that RAM:
// a prime step starts the first key read, ROUNDS rounds run, and a hold step moves the
// result into the output register once that register is free; the key expansion comes
// first when the schedule must run. One block is in work at a time: the next input
// beat is taken as soon as the finished block has moved into the output register,
// even while that result still waits on the master side.
`default_nettype none

`include "assert_macros.svh"

module speck_block_cipher #(
    parameter int ROUNDS = spk_pkg::ROUNDS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [spk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [spk_pkg::WORD_W-1:0]    i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0 up: block_x [63:0], block_y [127:64].
    input  wire logic [2*spk_pkg::WORD_W-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // Fields from bit 0 up: out_x [63:0], out_y [127:64].
    output logic      [2*spk_pkg::WORD_W-1:0]  m_axis_tdata
);

    localparam int IW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [IW-1:0] LAST = IW'(ROUNDS - 1);

    spk_pkg::t_word r_key0;
    spk_pkg::t_word r_key1;
    spk_pkg::t_word r_key2;
    spk_pkg::t_word r_key3;
    logic           r_dir;
    logic           r_keys_ready;

    spk_pkg::t_state r_state;
    spk_pkg::t_state n_state;
    logic [IW-1:0]   r_cnt;
    logic [IW-1:0]   n_cnt;
    logic [IW-1:0]   r_kidx;
    logic [IW-1:0]   n_kidx;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            n_keys_ready;
    spk_pkg::t_word  r_out_x;
    spk_pkg::t_word  r_out_y;

    spk_pkg::t_sched_ctl sched_ctl;
    spk_pkg::t_round_ctl round_ctl;
    logic            ram_we;
    logic [IW-1:0]   ram_raddr;
    spk_pkg::t_word  ram_rdata;
    spk_pkg::t_word  sched_rk;
    spk_pkg::t_word  cur_x;
    spk_pkg::t_word  cur_y;
    logic            in_beat;
    logic            out_load;

    assign s_axis_tready = (r_state == spk_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
            r_dir  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spk_pkg::CFG_KEY_WORD_0: r_key0 <= i_cfg_data;
                spk_pkg::CFG_KEY_WORD_1: r_key1 <= i_cfg_data;
                spk_pkg::CFG_KEY_WORD_2: r_key2 <= i_cfg_data;
                spk_pkg::CFG_KEY_WORD_3: r_key3 <= i_cfg_data;
                spk_pkg::CFG_DIRECTION:  r_dir  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= spk_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_kidx       <= '0;
            r_out_valid  <= 1'b0;
            r_keys_ready <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_kidx       <= n_kidx;
            r_out_valid  <= n_out_valid;
            r_keys_ready <= n_keys_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x <= cur_x;
            r_out_y <= cur_y;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_kidx       = r_kidx;
        n_keys_ready = r_keys_ready;
        n_out_valid  = r_out_valid && !m_axis_tready;
        sched_ctl    = '0;
        round_ctl    = '0;
        round_ctl.dir = r_dir;
        ram_we       = 1'b0;
        ram_raddr    = r_kidx;
        out_load     = 1'b0;

        if (i_cfg_we && (i_cfg_idx inside {spk_pkg::CFG_KEY_WORD_0, spk_pkg::CFG_KEY_WORD_1,
                                           spk_pkg::CFG_KEY_WORD_2, spk_pkg::CFG_KEY_WORD_3})) begin
            n_keys_ready = 1'b0;
        end

        case (r_state)
            spk_pkg::ST_IDLE: begin
                if (in_beat) begin
                    round_ctl.load = 1'b1;
                    n_cnt          = '0;
                    if (r_keys_ready) begin
                        n_state = spk_pkg::ST_PRIME;
                    end else begin
                        sched_ctl.load = 1'b1;
                        n_state        = spk_pkg::ST_SCHED;
                    end
                end
            end
            spk_pkg::ST_SCHED: begin
                sched_ctl.step = 1'b1;
                ram_we         = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_keys_ready = 1'b1;
                    n_cnt        = '0;
                    n_state      = spk_pkg::ST_PRIME;
                end
            end
            spk_pkg::ST_PRIME: begin
                ram_raddr = r_dir ? LAST : '0;
                n_kidx    = ram_raddr;
                n_cnt     = '0;
                n_state   = spk_pkg::ST_RUN;
            end
            spk_pkg::ST_RUN: begin
                round_ctl.step = 1'b1;
                ram_raddr      = r_dir ? (r_kidx - 1'b1) : (r_kidx + 1'b1);
                n_kidx         = ram_raddr;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = spk_pkg::ST_HOLD;
                end
            end
            spk_pkg::ST_HOLD: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = spk_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spk_pkg::ST_IDLE;
            end
        endcase
    end

    spk_ram #(
        .WIDTH(spk_pkg::WORD_W),
        .DEPTH(ROUNDS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (sched_rk),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spk_sched #(
        .ROUNDS(ROUNDS)
    ) u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_idx  (r_cnt),
        .i_key0 (r_key0),
        .i_key1 (r_key1),
        .i_key2 (r_key2),
        .i_key3 (r_key3),
        .o_rk   (sched_rk)
    );

    spk_round u_round (
        .i_clk (i_clk),
        .i_ctl (round_ctl),
        .i_x   (s_axis_tdata[spk_pkg::WORD_W-1:0]),
        .i_y   (s_axis_tdata[2*spk_pkg::WORD_W-1:spk_pkg::WORD_W]),
        .i_rk  (ram_rdata),
        .o_x   (cur_x),
        .o_y   (cur_y)
    );

    `AST_NEXT(a_sched_sets_ready,
              (r_state == spk_pkg::ST_SCHED) && (n_state == spk_pkg::ST_PRIME),
              r_keys_ready, "key schedule finished without marking keys ready")
    `AST_NEXT(a_prime_starts_run, r_state == spk_pkg::ST_PRIME,
              (r_state == spk_pkg::ST_RUN) && (r_cnt == '0), "round run did not start at zero")
    `AST_SAME(a_result_from_hold, $rose(m_axis_tvalid),
              $past(r_state) == spk_pkg::ST_HOLD, "result appeared outside the hold step")
    `AST_SAME(a_no_ram_write_in_run, r_state == spk_pkg::ST_RUN,
              !ram_we && r_keys_ready, "round keys written or stale during a round run")

endmodule

`default_nettype wire
